// ----- hw/rtl/glpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker package
// Shared codes, control structs and sizing helpers for the line walker.
// ----------------------------------------------------------------------------
package glpw_pkg;

   // Command carried by an input item.
   typedef enum logic {
      CMD_START    = 1'b0,
      CMD_CONTINUE = 1'b1
   } command_type;

   // Major axis of the walk.
   typedef enum logic [1:0] {
      AXIS_VERTICAL   = 2'd0,
      AXIS_HORIZONTAL = 2'd1,
      AXIS_DIAGONAL   = 2'd2
   } axis_mode_type;

   // Options latched by a start item.
   typedef struct packed {
      logic stop_at_occupant;
      logic info_mode;
      logic pass_through;
   } walk_flags_type;

   // Map status of the cell given last, sent with a continue item.
   typedef struct packed {
      logic projectable;
      logic believed_wall;
      logic occupied;
   } cell_status_type;

   // Path length counter width.
   localparam int LEN_W = 8;

   // Configuration port.
   localparam int             CSR_DATA_W          = 32;
   localparam int             CSR_ADDR_W          = 3;
   localparam logic           CSR_IDX_RANGE_LIMIT = 1'b0;
   localparam logic [LEN_W-1:0] RANGE_LIMIT_RESET = 8'd20;

   // Width of one classified item in the queue between front and back.
   // Layout: command, flags, status, same cell, mode, two step signs,
   // first row/col, target row/col, half unit and minor square.
   function automatic int entry_width(input int coord_bits);
      return 12 + 8 * coord_bits;
   endfunction

endpackage

// ----- hw/rtl/glpw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker queue
// Short register queue that decouples the classifier from the walk engine.
// ----------------------------------------------------------------------------
module glpw_queue #(
   parameter int WIDTH = 76,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/glpw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker front end
// Accepts items and classifies start items: deltas, axis, slope products.
// ----------------------------------------------------------------------------
module glpw_front #(
   parameter int COORD_BITS = 8
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic                  req_pass_through,
   input  logic                  req_info_mode,
   input  logic                  req_stop_at_occupant,
   input  logic                  req_cell_projectable,
   input  logic                  req_cell_believed_wall,
   input  logic                  req_cell_occupied,
   input  logic                  queue_full,
   output logic                  queue_push,
   output logic [glpw_pkg::entry_width(COORD_BITS)-1:0] queue_data
);

   localparam int CB     = COORD_BITS;
   localparam int PROD_W = 2 * COORD_BITS;

   // Same layout as in the back end.
   typedef struct packed {
      glpw_pkg::command_type     command;
      glpw_pkg::walk_flags_type  flags;
      glpw_pkg::cell_status_type status;
      logic                      same_cell;
      glpw_pkg::axis_mode_type   mode;
      logic                      row_neg;
      logic                      col_neg;
      logic [CB-1:0]             first_row;
      logic [CB-1:0]             first_col;
      logic [CB-1:0]             target_row;
      logic [CB-1:0]             target_col;
      logic [PROD_W-1:0]         half_unit;
      logic [PROD_W-1:0]         minor_sq;
   } entry_type;

   entry_type     ent;
   logic [CB-1:0] abs_y;
   logic [CB-1:0] abs_x;
   logic [CB-1:0] minor_len;

   function automatic logic [CB-1:0] step_coord(input logic [CB-1:0] v, input logic neg);
      return neg ? (v - CB'(1)) : (v + CB'(1));
   endfunction

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;
   assign queue_data = ent;

   always_comb begin
      ent.command                = glpw_pkg::command_type'(req_command);
      ent.flags.pass_through     = req_pass_through;
      ent.flags.info_mode        = req_info_mode;
      ent.flags.stop_at_occupant = req_stop_at_occupant;
      ent.status.projectable     = req_cell_projectable;
      ent.status.believed_wall   = req_cell_believed_wall;
      ent.status.occupied        = req_cell_occupied;
      ent.same_cell  = (req_start_y == req_end_y) && (req_start_x == req_end_x);
      ent.row_neg    = (req_end_y < req_start_y);
      ent.col_neg    = (req_end_x < req_start_x);
      ent.target_row = req_end_y;
      ent.target_col = req_end_x;

      abs_y = ent.row_neg ? (req_start_y - req_end_y) : (req_end_y - req_start_y);
      abs_x = ent.col_neg ? (req_start_x - req_end_x) : (req_end_x - req_start_x);
      ent.half_unit = PROD_W'(abs_y) * PROD_W'(abs_x);

      if (abs_y > abs_x) begin
         ent.mode  = glpw_pkg::AXIS_VERTICAL;
         minor_len = abs_x;
      end else if (abs_x > abs_y) begin
         ent.mode  = glpw_pkg::AXIS_HORIZONTAL;
         minor_len = abs_y;
      end else begin
         ent.mode  = glpw_pkg::AXIS_DIAGONAL;
         minor_len = '0;
      end
      ent.minor_sq = PROD_W'(minor_len) * PROD_W'(minor_len);

      ent.first_row = (ent.mode == glpw_pkg::AXIS_HORIZONTAL) ? req_start_y
                      : step_coord(req_start_y, ent.row_neg);
      ent.first_col = (ent.mode == glpw_pkg::AXIS_VERTICAL) ? req_start_x
                      : step_coord(req_start_x, ent.col_neg);
   end

endmodule

// ----- hw/rtl/glpw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker back end
// Walk engine: fraction stepper, stop checks and the result register.
// ----------------------------------------------------------------------------
module glpw_back #(
   parameter int COORD_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  logic [glpw_pkg::entry_width(COORD_BITS)-1:0] queue_data,
   output logic                  queue_pop,
   input  logic [glpw_pkg::LEN_W-1:0] range_limit,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_grid_y,
   output logic [COORD_BITS-1:0] rsp_grid_x,
   output logic                  rsp_grid_valid,
   output logic                  rsp_path_done,
   output logic [glpw_pkg::LEN_W-1:0] rsp_path_length
);

   localparam int CB     = COORD_BITS;
   localparam int PROD_W = 2 * COORD_BITS;
   localparam int FRAC_W = 2 * COORD_BITS + 4;
   localparam int LW     = glpw_pkg::LEN_W;

   // Same layout as in the front end.
   typedef struct packed {
      glpw_pkg::command_type     command;
      glpw_pkg::walk_flags_type  flags;
      glpw_pkg::cell_status_type status;
      logic                      same_cell;
      glpw_pkg::axis_mode_type   mode;
      logic                      row_neg;
      logic                      col_neg;
      logic [CB-1:0]             first_row;
      logic [CB-1:0]             first_col;
      logic [CB-1:0]             target_row;
      logic [CB-1:0]             target_col;
      logic [PROD_W-1:0]         half_unit;
      logic [PROD_W-1:0]         minor_sq;
   } entry_type;

   entry_type ent;

   // Walk state
   logic                     active_ff, active_in;
   glpw_pkg::axis_mode_type  mode_ff, mode_in;
   glpw_pkg::walk_flags_type flags_ff, flags_in;
   logic [CB-1:0]            row_ff, row_in;
   logic [CB-1:0]            col_ff, col_in;
   logic [CB-1:0]            tgt_row_ff, tgt_row_in;
   logic [CB-1:0]            tgt_col_ff, tgt_col_in;
   logic                     row_neg_ff, row_neg_in;
   logic                     col_neg_ff, col_neg_in;
   logic signed [FRAC_W-1:0] frac_ff, frac_in;
   logic [PROD_W-1:0]        half_ff, half_in;
   logic [PROD_W:0]          slope_ff, slope_in;
   logic [LW-1:0]            cells_ff, cells_in;
   logic [LW-1:0]            minor_ff, minor_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]            rsp_y_ff, rsp_y_in;
   logic [CB-1:0]            rsp_x_ff, rsp_x_in;
   logic                     rsp_gv_ff, rsp_gv_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic [LW-1:0]            rsp_len_ff, rsp_len_in;

   logic                     advance;
   logic                     give;
   logic                     stop;
   logic                     take_minor;
   logic                     range_hit;
   logic                     target_hit;
   logic [LW-1:0]            range_k;
   logic signed [FRAC_W-1:0] frac_sum;
   logic signed [FRAC_W-1:0] half_ext;

   function automatic logic [CB-1:0] step_coord(input logic [CB-1:0] v, input logic neg);
      return neg ? (v - CB'(1)) : (v + CB'(1));
   endfunction

   assign ent       = queue_data;
   assign advance   = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign queue_pop = advance;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grid_y      = rsp_y_ff;
   assign rsp_grid_x      = rsp_x_ff;
   assign rsp_grid_valid  = rsp_gv_ff;
   assign rsp_path_done   = rsp_done_ff;
   assign rsp_path_length = rsp_len_ff;

   always_comb begin
      active_in  = active_ff;
      mode_in    = mode_ff;
      flags_in   = flags_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      tgt_row_in = tgt_row_ff;
      tgt_col_in = tgt_col_ff;
      row_neg_in = row_neg_ff;
      col_neg_in = col_neg_ff;
      frac_in    = frac_ff;
      half_in    = half_ff;
      slope_in   = slope_ff;
      cells_in   = cells_ff;
      minor_in   = minor_ff;
      give       = 1'b0;
      take_minor = 1'b0;
      range_k    = '0;
      range_hit  = 1'b0;
      target_hit = 1'b0;

      half_ext = $signed(FRAC_W'(half_ff));
      frac_sum = frac_ff + $signed(FRAC_W'(slope_ff));

      // A wall stops the walk; info mode trusts the believed map instead.
      stop = (flags_ff.info_mode ? ent.status.believed_wall : !ent.status.projectable)
             || (flags_ff.stop_at_occupant && ent.status.occupied);

      if (ent.command == glpw_pkg::CMD_START) begin
         flags_in   = ent.flags;
         tgt_row_in = ent.target_row;
         tgt_col_in = ent.target_col;
         cells_in   = '0;
         minor_in   = '0;
         frac_in    = '0;
         half_in    = '0;
         slope_in   = '0;
         if (ent.same_cell) begin
            active_in = 1'b0;
         end else begin
            active_in  = 1'b1;
            mode_in    = ent.mode;
            row_neg_in = ent.row_neg;
            col_neg_in = ent.col_neg;
            half_in    = ent.half_unit;
            frac_in    = $signed(FRAC_W'(ent.minor_sq));
            slope_in   = {ent.minor_sq, 1'b0};
            row_in     = ent.first_row;
            col_in     = ent.first_col;
            give       = 1'b1;
         end
      end else if (!active_ff) begin
         active_in = 1'b0;
      end else if (stop) begin
         active_in = 1'b0;
      end else begin
         give = 1'b1;
         if (mode_ff == glpw_pkg::AXIS_DIAGONAL) begin
            row_in = step_coord(row_ff, row_neg_ff);
            col_in = step_coord(col_ff, col_neg_ff);
         end else begin
            if (slope_ff != '0) begin
               frac_in = frac_sum;
               if (frac_sum >= half_ext) begin
                  frac_in    = frac_sum - (half_ext <<< 1);
                  take_minor = 1'b1;
                  minor_in   = minor_ff + LW'(1);
               end
            end
            if (mode_ff == glpw_pkg::AXIS_VERTICAL) begin
               row_in = step_coord(row_ff, row_neg_ff);
               if (take_minor) begin
                  col_in = step_coord(col_ff, col_neg_ff);
               end
            end else begin
               col_in = step_coord(col_ff, col_neg_ff);
               if (take_minor) begin
                  row_in = step_coord(row_ff, row_neg_ff);
               end
            end
         end
      end

      if (give) begin
         cells_in   = cells_in + LW'(1);
         range_k    = (mode_in == glpw_pkg::AXIS_DIAGONAL) ? cells_in : minor_in;
         range_hit  = ({1'b0, cells_in} + {2'b00, range_k[LW-1:1]}) >= {1'b0, range_limit};
         target_hit = !flags_in.pass_through && (row_in == tgt_row_in)
                      && (col_in == tgt_col_in);
         if (range_hit || target_hit) begin
            active_in = 1'b0;
         end
      end

      rsp_y_in    = give ? row_in : '0;
      rsp_x_in    = give ? col_in : '0;
      rsp_gv_in   = give;
      rsp_done_in = give ? (range_hit || target_hit) : 1'b1;
      rsp_len_in  = cells_in;

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         mode_ff      <= glpw_pkg::AXIS_VERTICAL;
         flags_ff     <= '0;
         cells_ff     <= '0;
         minor_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            active_ff <= active_in;
            mode_ff   <= mode_in;
            flags_ff  <= flags_in;
            cells_ff  <= cells_in;
            minor_ff  <= minor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         tgt_row_ff  <= tgt_row_in;
         tgt_col_ff  <= tgt_col_in;
         row_neg_ff  <= row_neg_in;
         col_neg_ff  <= col_neg_in;
         frac_ff     <= frac_in;
         half_ff     <= half_in;
         slope_ff    <= slope_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_x_ff    <= rsp_x_in;
         rsp_gv_ff   <= rsp_gv_in;
         rsp_done_ff <= rsp_done_in;
         rsp_len_ff  <= rsp_len_in;
      end
   end

endmodule

// ----- hw/rtl/grid_line_path_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker
// Gives the grid cells of a line, one per item, with range and wall stops.
// ----------------------------------------------------------------------------
// Usage: send a start item (command 0) with origin, target and options; the
// result carries the first cell of the line. Each continue item (command 1)
// reports the map status of the cell just given and gets the next cell, or
// grid_valid 0 with path_done 1 when a wall or occupant ends the walk.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The user must write the range limit register over the APB-style
// csr_ port only while no item is in flight; the block does not enforce it.
// An accepted item waits in the classifier queue; the walk engine then takes
// it and registers its result in the result register, which offers it.
// Throughput: one item per cycle, start items too, while the receiver does
// not stall; set by the single fraction add, compare and subtract in the
// walk engine. When the receiver stalls, the result register holds and the
// two-entry queue keeps accepting until it is full, then req_stall rises.
// Reset clears the walk (no walk active, path length zero) and sets the
// range limit to 20.
// ----------------------------------------------------------------------------
module grid_line_path_walker #(
   parameter int COORD_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic                  req_pass_through,
   input  logic                  req_info_mode,
   input  logic                  req_stop_at_occupant,
   input  logic                  req_cell_projectable,
   input  logic                  req_cell_believed_wall,
   input  logic                  req_cell_occupied,
   // Result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_grid_y,
   output logic [COORD_BITS-1:0] rsp_grid_x,
   output logic                  rsp_grid_valid,
   output logic                  rsp_path_done,
   output logic [glpw_pkg::LEN_W-1:0] rsp_path_length,
   // Configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [glpw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [glpw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [glpw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ENTRY_W = glpw_pkg::entry_width(COORD_BITS);
   localparam int LW      = glpw_pkg::LEN_W;
   localparam int DW      = glpw_pkg::CSR_DATA_W;
   localparam int AW      = glpw_pkg::CSR_ADDR_W;

   logic [LW-1:0]      range_limit_ff, range_limit_in;
   logic               csr_hit;
   logic               queue_push;
   logic               queue_pop;
   logic               queue_empty;
   logic               queue_full;
   logic [ENTRY_W-1:0] push_data;
   logic [ENTRY_W-1:0] pop_data;

   // Registers sit at word addresses; the low two address bits are ignored.
   assign csr_hit    = (csr_paddr[AW-1:2] == glpw_pkg::CSR_IDX_RANGE_LIMIT);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? DW'(range_limit_ff) : '0;

   always_comb begin
      range_limit_in = range_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         range_limit_in = csr_pwdata[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_limit_ff <= glpw_pkg::RANGE_LIMIT_RESET;
      end else begin
         range_limit_ff <= range_limit_in;
      end
   end

   glpw_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_start_y            (req_start_y),
      .req_start_x            (req_start_x),
      .req_end_y              (req_end_y),
      .req_end_x              (req_end_x),
      .req_pass_through       (req_pass_through),
      .req_info_mode          (req_info_mode),
      .req_stop_at_occupant   (req_stop_at_occupant),
      .req_cell_projectable   (req_cell_projectable),
      .req_cell_believed_wall (req_cell_believed_wall),
      .req_cell_occupied      (req_cell_occupied),
      .queue_full             (queue_full),
      .queue_push             (queue_push),
      .queue_data             (push_data)
   );

   glpw_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   glpw_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_data      (pop_data),
      .queue_pop       (queue_pop),
      .range_limit     (range_limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_grid_y      (rsp_grid_y),
      .rsp_grid_x      (rsp_grid_x),
      .rsp_grid_valid  (rsp_grid_valid),
      .rsp_path_done   (rsp_path_done),
      .rsp_path_length (rsp_path_length)
   );

endmodule

// ----- hw/rtl/glpw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module glpw_checker #(
   parameter int COORD_BITS = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COORD_BITS-1:0] rsp_grid_y,
   input logic [COORD_BITS-1:0] rsp_grid_x,
   input logic                  rsp_grid_valid,
   input logic                  rsp_path_done,
   input logic [glpw_pkg::LEN_W-1:0] rsp_path_length
);

   // A stalled result item stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A stalled result item keeps its payload.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_grid_y) && $stable(rsp_grid_x)
         && $stable(rsp_grid_valid) && $stable(rsp_path_done)
         && $stable(rsp_path_length))
      else $error("result payload changed while stalled");

   // An item that gives no cell always ends the walk.
   a_no_cell_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_grid_valid |-> rsp_path_done)
      else $error("result without a cell did not end the walk");

   // An item that gives no cell shows zero coordinates.
   a_no_cell_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_grid_valid |-> (rsp_grid_y == '0) && (rsp_grid_x == '0))
      else $error("result without a cell has nonzero coordinates");

   // A given cell is always counted, so the length is never zero.
   a_cell_counted : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_valid |-> (rsp_path_length != '0))
      else $error("given cell has zero path length");

endmodule

bind grid_line_path_walker glpw_checker #(
   .COORD_BITS(COORD_BITS)
) u_glpw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_grid_y      (rsp_grid_y),
   .rsp_grid_x      (rsp_grid_x),
   .rsp_grid_valid  (rsp_grid_valid),
   .rsp_path_done   (rsp_path_done),
   .rsp_path_length (rsp_path_length)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line path walker testbench
// Sends start and continue items through the valid/stall request channel and
// predicts every result cell with a cycle-free model of the line stepper. A
// short table of directed items comes first; random walks follow, across
// several range limits and with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
   import glpw_pkg::*;

   localparam int COORD_BITS = 8;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 240;
   localparam logic [CSR_ADDR_W-1:0] RANGE_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_RANGE_LIMIT));

   typedef logic [COORD_BITS-1:0] coord_t;
   typedef logic [LEN_W-1:0] count_t;

   typedef struct packed {
      command_type     cmd;
      coord_t          start_y;
      coord_t          start_x;
      coord_t          end_y;
      coord_t          end_x;
      walk_flags_type  flags;
      cell_status_type status;
   } walk_item_t;

   typedef struct packed {
      coord_t grid_y;
      coord_t grid_x;
      logic   grid_valid;
      logic   path_done;
      count_t path_length;
   } cell_result_t;

   typedef struct {
      walk_item_t   item;
      bit           pinned;
      cell_result_t want;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic   req_valid = 1'b0;
   logic   req_stall;
   logic   req_command = 1'b0;
   coord_t req_start_y = '0;
   coord_t req_start_x = '0;
   coord_t req_end_y = '0;
   coord_t req_end_x = '0;
   logic   req_pass_through = 1'b0;
   logic   req_info_mode = 1'b0;
   logic   req_stop_at_occupant = 1'b0;
   logic   req_cell_projectable = 1'b0;
   logic   req_cell_believed_wall = 1'b0;
   logic   req_cell_occupied = 1'b0;

   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   coord_t rsp_grid_y;
   coord_t rsp_grid_x;
   logic   rsp_grid_valid;
   logic   rsp_path_done;
   count_t rsp_path_length;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grid_line_path_walker #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_start_y            (req_start_y),
      .req_start_x            (req_start_x),
      .req_end_y              (req_end_y),
      .req_end_x              (req_end_x),
      .req_pass_through       (req_pass_through),
      .req_info_mode          (req_info_mode),
      .req_stop_at_occupant   (req_stop_at_occupant),
      .req_cell_projectable   (req_cell_projectable),
      .req_cell_believed_wall (req_cell_believed_wall),
      .req_cell_occupied      (req_cell_occupied),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_grid_y             (rsp_grid_y),
      .rsp_grid_x             (rsp_grid_x),
      .rsp_grid_valid         (rsp_grid_valid),
      .rsp_path_done          (rsp_path_done),
      .rsp_path_length        (rsp_path_length),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   // Walk state as the line stepper should hold it.
   logic           walking = 1'b0;
   axis_mode_type  axis = AXIS_VERTICAL;
   coord_t         cur_y = '0;
   coord_t         cur_x = '0;
   coord_t         goal_y = '0;
   coord_t         goal_x = '0;
   logic           y_down = 1'b0;
   logic           x_down = 1'b0;
   int             frac = 0;
   int             half_span = 0;
   int             frac_step = 0;
   count_t         cells_out = '0;
   count_t         minor_moves = '0;
   walk_flags_type walk_opts = '0;
   count_t         range_limit = RANGE_LIMIT_RESET;

   cell_result_t expected_cells[$];
   int           mismatches = 0;
   int           results_seen = 0;
   int           src_idle_pct = 0;
   int           sink_idle_pct = 0;
   int           stall_left = 0;

   int src_pcts[PHASES]  = '{15, 30, 0, 0, 40, 10, 25, 0};
   int sink_pcts[PHASES] = '{15, 0, 30, 0, 40, 25, 10, 0};

   // Status bits are {projectable, believed_wall, occupied}; flags are
   // {stop_at_occupant, info_mode, pass_through}.
   directed_row_t directed_rows[24] = '{
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 8'd0}},
      '{'{CMD_START, 8'd5, 8'd5, 8'd5, 8'd5, 3'b000, 3'b111}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 8'd0}},
      '{'{CMD_START, 8'd0, 8'd0, 8'd0, 8'd255, 3'b000, 3'b000}, 1'b1,
        '{8'd0, 8'd1, 1'b1, 1'b0, 8'd1}},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b010}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 8'd2}},
      '{'{CMD_START, 8'd255, 8'd255, 8'd0, 8'd0, 3'b000, 3'b000}, 1'b1,
        '{8'd254, 8'd254, 1'b1, 1'b0, 8'd1}},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0},
      '{'{CMD_START, 8'd10, 8'd10, 8'd12, 8'd11, 3'b110, 3'b000}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b000}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 8'd2}},
      '{'{CMD_START, 8'd100, 8'd100, 8'd103, 8'd104, 3'b110, 3'b000}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b101}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 8'd1}},
      '{'{CMD_START, 8'd254, 8'd3, 8'd255, 8'd3, 3'b001, 3'b000}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0},
      '{'{CMD_START, 8'd7, 8'd7, 8'd0, 8'd9, 3'b000, 3'b010}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b110}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b101}, 1'b0, '0},
      '{'{CMD_START, 8'd0, 8'd255, 8'd255, 8'd0, 3'b010, 3'b000}, 1'b1,
        '{8'd1, 8'd254, 1'b1, 1'b0, 8'd1}},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b010}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 8'd1}},
      '{'{CMD_START, 8'd40, 8'd30, 8'd43, 8'd41, 3'b000, 3'b000}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0},
      '{'{CMD_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd0, 3'b000, 3'b100}, 1'b0, '0}
   };

   function automatic coord_t next_coord(input coord_t v, input logic down);
      return down ? v - 1'b1 : v + 1'b1;
   endfunction

   // Counts the cell now under the walker and decides whether the walk ends.
   function automatic cell_result_t offer_cell();
      cell_result_t r;
      count_t       k;
      logic         done;
      cells_out = cells_out + 1'b1;
      k = (axis == AXIS_DIAGONAL) ? cells_out : minor_moves;
      done = (int'(cells_out) + int'(k >> 1)) >= int'(range_limit);
      if (!walk_opts.pass_through && cur_y == goal_y && cur_x == goal_x)
         done = 1'b1;
      if (done)
         walking = 1'b0;
      r.grid_y = cur_y;
      r.grid_x = cur_x;
      r.grid_valid = 1'b1;
      r.path_done = done;
      r.path_length = cells_out;
      return r;
   endfunction

   function automatic cell_result_t advance_walk(input walk_item_t it);
      cell_result_t r;
      int           ay;
      int           ax;
      logic         stop_now;
      logic         minor;
      r = '0;
      r.path_done = 1'b1;
      if (it.cmd == CMD_START) begin
         walk_opts = it.flags;
         goal_y = it.end_y;
         goal_x = it.end_x;
         cells_out = '0;
         minor_moves = '0;
         frac = 0;
         half_span = 0;
         frac_step = 0;
         if (it.start_y == it.end_y && it.start_x == it.end_x) begin
            walking = 1'b0;
            cur_y = it.start_y;
            cur_x = it.start_x;
            return r;
         end
         y_down = it.end_y < it.start_y;
         x_down = it.end_x < it.start_x;
         ay = y_down ? int'(it.start_y) - int'(it.end_y) : int'(it.end_y) - int'(it.start_y);
         ax = x_down ? int'(it.start_x) - int'(it.end_x) : int'(it.end_x) - int'(it.start_x);
         half_span = ay * ax;
         if (ay > ax) begin
            axis = AXIS_VERTICAL;
            frac = ax * ax;
            frac_step = 2 * frac;
            cur_y = next_coord(it.start_y, y_down);
            cur_x = it.start_x;
         end else if (ax > ay) begin
            axis = AXIS_HORIZONTAL;
            frac = ay * ay;
            frac_step = 2 * frac;
            cur_y = it.start_y;
            cur_x = next_coord(it.start_x, x_down);
         end else begin
            axis = AXIS_DIAGONAL;
            cur_y = next_coord(it.start_y, y_down);
            cur_x = next_coord(it.start_x, x_down);
         end
         walking = 1'b1;
         return offer_cell();
      end
      r.path_length = cells_out;
      if (!walking)
         return r;
      stop_now = walk_opts.info_mode ? it.status.believed_wall : !it.status.projectable;
      if (walk_opts.stop_at_occupant && it.status.occupied)
         stop_now = 1'b1;
      if (stop_now) begin
         walking = 1'b0;
         return r;
      end
      if (axis == AXIS_DIAGONAL) begin
         cur_y = next_coord(cur_y, y_down);
         cur_x = next_coord(cur_x, x_down);
      end else begin
         minor = 1'b0;
         if (frac_step != 0) begin
            frac += frac_step;
            if (frac >= half_span) begin
               frac -= 2 * half_span;
               minor = 1'b1;
               minor_moves = minor_moves + 1'b1;
            end
         end
         if (axis == AXIS_VERTICAL) begin
            if (minor)
               cur_x = next_coord(cur_x, x_down);
            cur_y = next_coord(cur_y, y_down);
         end else begin
            if (minor)
               cur_y = next_coord(cur_y, y_down);
            cur_x = next_coord(cur_x, x_down);
         end
      end
      return offer_cell();
   endfunction

   // A start item with a random line: short, medium, anywhere, straight or diagonal.
   function automatic walk_item_t random_start();
      walk_item_t it;
      int         dy;
      int         dx;
      int         t;
      it.cmd = CMD_START;
      it.start_y = coord_t'($urandom);
      it.start_x = coord_t'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            dy = int'($urandom_range(0, 12)) - 6;
            dx = int'($urandom_range(0, 12)) - 6;
         end
         1: begin
            dy = int'($urandom_range(0, 80)) - 40;
            dx = int'($urandom_range(0, 80)) - 40;
         end
         2: begin
            dy = int'($urandom_range(0, 255));
            dx = int'($urandom_range(0, 255));
         end
         default: begin
            dy = int'($urandom_range(0, 60)) - 30;
            case ($urandom_range(0, 2))
               0: dx = 0;
               1: dx = dy;
               default: dx = -dy;
            endcase
            if ($urandom_range(0, 1)) begin
               t = dy;
               dy = dx;
               dx = t;
            end
         end
      endcase
      it.end_y = coord_t'(int'(it.start_y) + dy);
      it.end_x = coord_t'(int'(it.start_x) + dx);
      it.flags.pass_through = ($urandom_range(0, 3) == 0);
      it.flags.info_mode = 1'($urandom_range(0, 1));
      it.flags.stop_at_occupant = 1'($urandom_range(0, 1));
      it.status = cell_status_type'(3'($urandom_range(0, 7)));
      return it;
   endfunction

   // Mostly follows the walk in progress with clear cells; now and then a
   // blocking cell, a new start mid-walk, or a continue with no walk.
   function automatic walk_item_t next_random_item();
      walk_item_t it;
      int         pick;
      it = random_start();
      pick = $urandom_range(0, 99);
      if (walking ? pick < 94 : pick < 8) begin
         it.cmd = CMD_CONTINUE;
         if (walking && $urandom_range(0, 29) != 0) begin
            if (!walk_opts.info_mode)
               it.status.projectable = 1'b1;
            else
               it.status.believed_wall = 1'b0;
            if (walk_opts.stop_at_occupant)
               it.status.occupied = 1'b0;
         end
      end
      return it;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got,
                  want);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input walk_item_t it, input cell_result_t want);
      expected_cells.push_back(want);
      if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_command <= it.cmd;
      req_start_y <= it.start_y;
      req_start_x <= it.start_x;
      req_end_y <= it.end_y;
      req_end_x <= it.end_x;
      req_pass_through <= it.flags.pass_through;
      req_info_mode <= it.flags.info_mode;
      req_stop_at_occupant <= it.flags.stop_at_occupant;
      req_cell_projectable <= it.status.projectable;
      req_cell_believed_wall <= it.status.believed_wall;
      req_cell_occupied <= it.status.occupied;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_range(input count_t value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= RANGE_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      range_limit = value;
   endtask

   // Result side back-pressure in bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
         stall_left = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      cell_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("result with nothing outstanding", 1, 0);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_grid_y !== want.grid_y)
               report_mismatch("grid_y", rsp_grid_y, want.grid_y);
            if (rsp_grid_x !== want.grid_x)
               report_mismatch("grid_x", rsp_grid_x, want.grid_x);
            if (rsp_grid_valid !== want.grid_valid)
               report_mismatch("grid_valid", rsp_grid_valid, want.grid_valid);
            if (rsp_path_done !== want.path_done)
               report_mismatch("path_done", rsp_path_done, want.path_done);
            if (rsp_path_length !== want.path_length)
               report_mismatch("path_length", rsp_path_length, want.path_length);
         end
         results_seen++;
      end
   end

   initial begin : stimulus
      cell_result_t predicted;
      walk_item_t   it;
      count_t       limit;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         predicted = advance_walk(directed_rows[i].item);
         send_item(directed_rows[i].item,
                   directed_rows[i].pinned ? directed_rows[i].want : predicted);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            repeat (4) @(negedge clock);
            case (p)
               1: limit = 8'd1;
               2: limit = 8'd255;
               3: limit = count_t'($urandom_range(3, 60));
               4: limit = 8'd2;
               5: limit = count_t'($urandom_range(1, 255));
               6: limit = 8'd8;
               default: limit = count_t'($urandom_range(10, 40));
            endcase
            write_range(limit);
         end
         src_idle_pct = src_pcts[p];
         sink_idle_pct = sink_pcts[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = next_random_item();
            send_item(it, advance_walk(it));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
